// ----- hw/rtl/gstu_pkg.sv -----
package gstu_pkg;

   // grid geometry
   localparam int MAX_SIDE = 8;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int SIZE_W   = 4;
   localparam int CELL_W   = 4 * COORD_W;
   localparam int CELLS    = MAX_SIDE ** 4;
   localparam int COUNT_W  = 13;
   localparam int DOOR_W   = 8;
   localparam int DIR_W    = 2;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_JOIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OPENED       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NBR_OUTSIDE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY_DOOR = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SAME_REGION  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CELL_OUTSIDE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DONE         = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_D = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_LOOKUP,
      S_DECIDE,
      S_DOOR_THERE,
      S_RELABEL,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic init_sweep;
      logic decide;
      logic door_there;
      logic relabel;
      logic ld_result;
   } dp_cmd_type;

   typedef struct packed {
      logic req_is_init;
      logic join_ok;
      logic sweep_last;
   } dp_stat_type;

   // zero acts as one, above the maximum clamps
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (s > SIZE_W'(MAX_SIDE)) begin
         r = SIZE_W'(MAX_SIDE);
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/gstu_if.sv -----
interface gstu_req_if
   import gstu_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] coord_a;
   logic [COORD_W-1:0] coord_b;
   logic [COORD_W-1:0] coord_c;
   logic [COORD_W-1:0] coord_d;
   logic [DIR_W-1:0]   direction;

   modport source (output valid, cmd, coord_a, coord_b, coord_c, coord_d, direction,
                   input ready);
   modport sink   (input valid, cmd, coord_a, coord_b, coord_c, coord_d, direction,
                   output ready);
endinterface

interface gstu_rsp_if
   import gstu_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DOOR_W-1:0]   door_mask;
   logic [COUNT_W-1:0]  parts_left;
   logic                complete;

   modport source (output valid, status, door_mask, parts_left, complete, input ready);
   modport sink   (input valid, status, door_mask, parts_left, complete, output ready);
endinterface

// ----- hw/rtl/gstu_ctrl.sv -----
module gstu_ctrl
   import gstu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.req_is_init ? S_INIT : S_LOOKUP;
            end
         end
         S_INIT: begin
            cmd.init_sweep = 1'b1;
            if (stat.sweep_last) state_in = S_FINISH;
         end
         S_LOOKUP: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.join_ok ? S_DOOR_THERE : S_FINISH;
         end
         S_DOOR_THERE: begin
            cmd.door_there = 1'b1;
            state_in       = S_RELABEL;
         end
         S_RELABEL: begin
            cmd.relabel = 1'b1;
            if (stat.sweep_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ld_result = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output slot: filled on load, freed when taken
   always_comb begin
      if (cmd.ld_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/gstu_datapath.sv -----
module gstu_datapath
   import gstu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [COORD_W-1:0]   req_coord_a,
   input  logic [COORD_W-1:0]   req_coord_b,
   input  logic [COORD_W-1:0]   req_coord_c,
   input  logic [COORD_W-1:0]   req_coord_d,
   input  logic [DIR_W-1:0]     req_direction,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [DOOR_W-1:0]    rsp_door_mask,
   output logic [COUNT_W-1:0]   rsp_parts_left,
   output logic                 rsp_complete
);

   localparam int HALF_W = DOOR_W / 2;

   // label and door stores
   logic [CELL_W-1:0] label_mem [CELLS];
   logic [DOOR_W-1:0] door_mem  [CELLS];

   logic [SIZE_W-1:0]   size_ff [4];
   logic [SIZE_W-1:0]   eff_a, eff_b, eff_c, eff_d;

   logic [CMD_W-1:0]    cmd_ff;
   logic [DIR_W-1:0]    dir_ff;
   logic [CELL_W-1:0]   here_ff, there_ff;
   logic                inside_ff, nbr_out_ff;
   logic [CELL_W-1:0]   from_ff, to_ff;
   logic [CELL_W-1:0]   lbl_rd1_ff, lbl_rd2_ff;
   logic [DOOR_W-1:0]   door_rd_ff;
   logic [CELL_W-1:0]   sweep_ff, sweep_in;
   logic                pend_ff;
   logic [CELL_W-1:0]   pend_addr_ff;
   logic [COUNT_W-1:0]  prod_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [DOOR_W-1:0]   mask_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [DOOR_W-1:0]   out_mask_ff;
   logic [COUNT_W-1:0]  out_count_ff;

   logic [SIZE_W-1:0]   na, nb, nc, nd;
   logic                req_inside, req_nbr_out;
   logic [HALF_W-1:0]   dir_onehot;
   logic [DOOR_W-1:0]   pos_bit, neg_bit;
   logic                join_ok;
   logic [STATUS_W-1:0] dec_status;
   logic [DOOR_W-1:0]   dec_mask;
   logic [CELL_W-1:0]   lbl_raddr1;
   logic [DOOR_W-1:0]   door_raddr_sel;
   logic                lbl_we;
   logic [CELL_W-1:0]   lbl_waddr, lbl_wdata;
   logic                door_we;
   logic [CELL_W-1:0]   door_waddr, door_raddr;
   logic [DOOR_W-1:0]   door_wdata;
   logic [SIZE_W-1:0]   factor;
   logic [COUNT_W+SIZE_W-1:0] prod_full;

   assign eff_a = eff_size(size_ff[0]);
   assign eff_b = eff_size(size_ff[1]);
   assign eff_c = eff_size(size_ff[2]);
   assign eff_d = eff_size(size_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SIZE_W'(MAX_SIDE);
         size_ff[1] <= SIZE_W'(MAX_SIDE);
         size_ff[2] <= SIZE_W'(MAX_SIDE);
         size_ff[3] <= SIZE_W'(MAX_SIDE);
      end else if (csr_we) begin
         size_ff[csr_index] <= csr_wdata;
      end
   end

   // incoming cell and neighbour geometry
   always_comb begin
      na = {1'b0, req_coord_a} + SIZE_W'(req_direction == 2'd0);
      nb = {1'b0, req_coord_b} + SIZE_W'(req_direction == 2'd1);
      nc = {1'b0, req_coord_c} + SIZE_W'(req_direction == 2'd2);
      nd = {1'b0, req_coord_d} + SIZE_W'(req_direction == 2'd3);
      req_inside  = ({1'b0, req_coord_a} < eff_a) && ({1'b0, req_coord_b} < eff_b) &&
                    ({1'b0, req_coord_c} < eff_c) && ({1'b0, req_coord_d} < eff_d);
      req_nbr_out = (na >= eff_a) || (nb >= eff_b) || (nc >= eff_c) || (nd >= eff_d);
   end

   assign dir_onehot = HALF_W'(1) << dir_ff;
   assign pos_bit    = {{HALF_W{1'b0}}, dir_onehot};
   assign neg_bit    = {dir_onehot, {HALF_W{1'b0}}};

   // decision on the looked-up door and labels
   always_comb begin
      join_ok    = 1'b0;
      dec_status = ST_OPENED;
      dec_mask   = door_rd_ff;
      if (cmd_ff == CMD_JOIN) begin
         priority if (count_ff <= COUNT_W'(1)) begin
            dec_status = ST_DONE;
            if (!inside_ff) dec_mask = '0;
         end else if (!inside_ff) begin
            dec_status = ST_CELL_OUTSIDE;
            dec_mask   = '0;
         end else if (nbr_out_ff) begin
            dec_status = ST_NBR_OUTSIDE;
         end else if ((door_rd_ff & pos_bit) != '0) begin
            dec_status = ST_ALREADY_DOOR;
         end else if (lbl_rd1_ff == lbl_rd2_ff) begin
            dec_status = ST_SAME_REGION;
         end else begin
            join_ok  = 1'b1;
            dec_mask = door_rd_ff | pos_bit;
         end
      end else if (!inside_ff) begin
         dec_status = ST_CELL_OUTSIDE;
         dec_mask   = '0;
      end
   end

   assign stat.req_is_init = (req_cmd == CMD_INIT);
   assign stat.join_ok     = cmd.decide && join_ok;
   assign stat.sweep_last  = (sweep_ff == CELL_W'(CELLS - 1));

   assign sweep_in = (cmd.init_sweep || cmd.relabel) ? sweep_ff + CELL_W'(1) : sweep_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         sweep_ff <= cmd.load ? '0 : sweep_in;
         pend_ff  <= cmd.relabel;
         if (cmd.init_sweep && stat.sweep_last) begin
            count_ff <= prod_ff;
         end else if (cmd.decide && join_ok) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

   // cell total over the first sweep cycles, one multiply per cycle
   always_comb begin
      unique case (sweep_ff[1:0])
         2'd0:    factor = eff_b;
         2'd1:    factor = eff_c;
         default: factor = eff_d;
      endcase
      prod_full = prod_ff * factor;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= req_cmd;
         dir_ff     <= req_direction;
         here_ff    <= {req_coord_a, req_coord_b, req_coord_c, req_coord_d};
         there_ff   <= {na[COORD_W-1:0], nb[COORD_W-1:0], nc[COORD_W-1:0], nd[COORD_W-1:0]};
         inside_ff  <= req_inside;
         nbr_out_ff <= req_nbr_out;
         prod_ff    <= COUNT_W'(eff_a);
         status_ff  <= ST_OPENED;
         mask_ff    <= '0;
      end else begin
         if (cmd.init_sweep && sweep_ff < CELL_W'(3)) prod_ff <= prod_full[COUNT_W-1:0];
         if (cmd.decide) begin
            status_ff <= dec_status;
            mask_ff   <= dec_mask;
            from_ff   <= lbl_rd1_ff;
            to_ff     <= lbl_rd2_ff;
         end
      end
      pend_addr_ff <= sweep_ff;
      if (cmd.ld_result) begin
         out_status_ff <= status_ff;
         out_mask_ff   <= mask_ff;
         out_count_ff  <= count_ff;
      end
   end

   // label store: one write, two registered reads
   always_comb begin
      lbl_raddr1 = cmd.relabel ? sweep_ff : here_ff;
      lbl_we     = 1'b0;
      lbl_waddr  = sweep_ff;
      lbl_wdata  = sweep_ff;
      if (cmd.init_sweep) begin
         lbl_we = 1'b1;
      end else if (pend_ff && lbl_rd1_ff == to_ff) begin
         lbl_we    = 1'b1;
         lbl_waddr = pend_addr_ff;
         lbl_wdata = from_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lbl_we) label_mem[lbl_waddr] <= lbl_wdata;
      lbl_rd1_ff <= label_mem[lbl_raddr1];
      lbl_rd2_ff <= label_mem[there_ff];
   end

   // door store: one write, one registered read
   always_comb begin
      door_raddr     = cmd.decide ? there_ff : here_ff;
      door_raddr_sel = door_rd_ff | neg_bit;
      door_we        = 1'b0;
      door_waddr     = sweep_ff;
      door_wdata     = '0;
      if (cmd.init_sweep) begin
         door_we = 1'b1;
      end else if (cmd.decide && join_ok) begin
         door_we    = 1'b1;
         door_waddr = here_ff;
         door_wdata = dec_mask;
      end else if (cmd.door_there) begin
         door_we    = 1'b1;
         door_waddr = there_ff;
         door_wdata = door_raddr_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (door_we) door_mem[door_waddr] <= door_wdata;
      door_rd_ff <= door_mem[door_raddr];
   end

   assign rsp_status     = out_status_ff;
   assign rsp_door_mask  = out_mask_ff;
   assign rsp_parts_left = out_count_ff;
   assign rsp_complete   = (out_count_ff == COUNT_W'(1));

endmodule

// ----- hw/rtl/grid_spanning_tree_union_unit.sv -----
// sequence: reads and rejected joins pass lookup and decide, init sweeps every cell, an
// opening join adds door update and relabel sweep; init and relabel sweep the label store
// one cell per cycle; one transaction in process, next accept the cycle after the result
// is loaded; a waiting result does not block that accept
// reset: synchronous, active high; sizes return to 8, region count to zero,
// stores hold garbage until the first init transaction
module grid_spanning_tree_union_unit
   import gstu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   gstu_req_if.sink             req_ch,
   gstu_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: accept, init sweep, lookup, decide, door update, relabel sweep, result hand-off
   gstu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // datapath: size registers, label and door stores, region count, result register
   gstu_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .req_cmd        (req_ch.cmd),
      .req_coord_a    (req_ch.coord_a),
      .req_coord_b    (req_ch.coord_b),
      .req_coord_c    (req_ch.coord_c),
      .req_coord_d    (req_ch.coord_d),
      .req_direction  (req_ch.direction),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_ch.status),
      .rsp_door_mask  (rsp_ch.door_mask),
      .rsp_parts_left (rsp_ch.parts_left),
      .rsp_complete   (rsp_ch.complete)
   );

endmodule

// ----- hw/rtl/gstu_checker.sv -----
module gstu_checker
   import gstu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [DOOR_W-1:0]   rsp_door_mask,
   input logic [COUNT_W-1:0]  rsp_parts_left,
   input logic                rsp_complete
);

   // a pending result is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_complete == (rsp_parts_left == COUNT_W'(1)))
      else $error("complete flag disagrees with region count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CELL_OUTSIDE |-> rsp_door_mask == '0)
      else $error("door mask for a cell outside the grid");

   // rejections past the done check only happen with several regions left
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NBR_OUTSIDE || rsp_status == ST_ALREADY_DOOR ||
                    rsp_status == ST_SAME_REGION) |-> rsp_parts_left > COUNT_W'(1))
      else $error("join rejected with at most one region");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DONE |-> rsp_parts_left <= COUNT_W'(1))
      else $error("done status with several regions left");

endmodule

bind grid_spanning_tree_union_unit gstu_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_door_mask  (rsp_ch.door_mask),
   .rsp_parts_left (rsp_ch.parts_left),
   .rsp_complete   (rsp_ch.complete)
);
